// ===== sv/fla_pkg.sv =====
package fla_pkg;

  localparam int unsigned HeapBytesDef   = 65536;
  localparam int unsigned BlockSlotsDef  = 256;
  localparam int unsigned HeaderBytesDef = 24;

  localparam int unsigned AddrW = 16;
  localparam int unsigned SizeW = 17;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoMem   = 2'd1,
    StBadFree = 2'd2,
    StFull    = 2'd3
  } status_e;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam int unsigned CfgFitMode  = 0;
  localparam int unsigned CfgCapacity = 1;

  // one block table entry
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [SizeW-1:0] bytes;
    logic             is_free;
  } entry_t;

endpackage

// ===== sv/fla_if.sv =====
interface fla_req_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [fla_pkg::AddrW-1:0] request_bytes;
  logic [fla_pkg::AddrW-1:0] payload_address;
  modport source (output valid, op, request_bytes, payload_address, input ready);
  modport sink (input valid, op, request_bytes, payload_address, output ready);
endinterface

interface fla_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [fla_pkg::AddrW-1:0] result_address;
  logic [fla_pkg::SizeW-1:0] heap_used;
  logic [fla_pkg::SizeW-1:0] free_bytes;
  modport source (output valid, status, result_address, heap_used, free_bytes, input ready);
  modport sink (input valid, status, result_address, heap_used, free_bytes, output ready);
endinterface

// ===== sv/fla_table.sv =====
// Block table memory: one write port, one registered read port
module fla_table #(
  parameter int unsigned Slots = fla_pkg::BlockSlotsDef,
  localparam int unsigned IdxW = $clog2(Slots)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  fla_pkg::entry_t  wdata_i,
  input  logic [IdxW-1:0]  raddr_i,
  output fla_pkg::entry_t  rdata_o
);

  fla_pkg::entry_t mem [Slots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/free_list_block_allocator_unit.sv =====
// Channel   | Dir | Payload
// req       | in  | op, request_bytes, payload_address
// rsp       | out | status, result_address, heap_used, free_bytes
// apb       | in  | fit_mode @0, heap_capacity @4
//
// One word is worked on at a time. The block table has one write and one
// registered read per cycle, so every table step is a read and then a check
// or write. A scan reads and then checks each entry visited. A split shifts
// the later entries up, each with a read and a write. A free reads each
// neighbor that exists, then after a merge shifts the later entries down,
// each with a read and a write.
// Reset clears the counters and config; entries above the count are never
// read, so the table needs no clearing.
// A finished word waits in an output register, so the next request is taken
// while the sink stalls; its response then waits until that register frees.
module free_list_block_allocator_unit #(
  parameter int unsigned HeapBytes   = fla_pkg::HeapBytesDef,
  parameter int unsigned BlockSlots  = fla_pkg::BlockSlotsDef,
  parameter int unsigned HeaderBytes = fla_pkg::HeaderBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fla_req_if.sink     req,
  fla_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = $clog2(BlockSlots);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned AW   = fla_pkg::AddrW;
  localparam int unsigned SW   = fla_pkg::SizeW;
  localparam int unsigned LimRaw = (HeapBytes < 65536) ? HeapBytes : 65536;
  localparam logic [SW-1:0]   HdrS    = SW'(HeaderBytes);
  localparam logic [AW-1:0]   HdrA    = AW'(HeaderBytes);
  localparam logic [SW:0]     LimP    = (SW+1)'(LimRaw);
  localparam logic [SW:0]     AddrTop = (SW+1)'(65535);
  localparam logic [CntW-1:0] SlotsC  = CntW'(BlockSlots);
  localparam logic [SW-1:0]   CapRst  = SW'(65536);

  typedef enum logic [3:0] {
    Idle, ScanRd, ScanChk, Decide, ShUpRd, ShUpWr, WrHi, NbUpRd,
    NbUpChk, NbLoRd, NbLoChk, MrgSet, ShDnRd, ShDnWr, FinWr, Resp
  } state_e;

  state_e state_q;
  logic             fit_q;
  logic [SW-1:0]    cap_q;
  logic [CntW-1:0]  count_q;
  logic [SW-1:0]    brk_q, ftot_q;
  logic             op_q;
  logic [AW-1:0]    req_q, fad_q;
  logic [CntW-1:0]  i_q, best_q, pos_q, j_q;
  logic             found_q;
  logic             up_q;      // upper neighbor merged
  logic [1:0]       k_q;       // entries removed by merging
  fla_pkg::entry_t  best_e_q, shift_q;
  logic [1:0]       status_q;
  logic [AW-1:0]    res_q;

  // output register
  logic             ovalid_q;
  logic [1:0]       ost_q;
  logic [AW-1:0]    oaddr_q;
  logic [SW-1:0]    oused_q, ofree_q;
  logic             load_out;

  // table port
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  fla_pkg::entry_t wdata, rdata;

  fla_table #(.Slots(BlockSlots)) u_table (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // APB
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'(fla_pkg::CfgFitMode)) prdata[0] = fit_q;
    else prdata[SW-1:0] = cap_q;
  end

  assign req.ready          = (state_q == Idle);
  assign rsp.valid          = ovalid_q;
  assign rsp.status         = ost_q;
  assign rsp.result_address = oaddr_q;
  assign rsp.heap_used      = oused_q;
  assign rsp.free_bytes     = ofree_q;
  assign load_out = (state_q == Resp) && (!ovalid_q || rsp.ready);

  // fit check on the entry just read
  logic [SW-1:0]   pay, need, rem;
  logic            elig, ge, eq, addr_hit;
  logic [SW:0]     lim, brk_need, brk_hdr;
  logic [CntW-1:0] up_idx, lo_idx, src0, cnt_end;
  assign pay      = rdata.bytes - HdrS;
  assign elig     = rdata.is_free && (rdata.bytes >= HdrS);
  assign ge       = pay >= SW'(req_q);
  assign eq       = pay == SW'(req_q);
  assign addr_hit = ({1'b0, rdata.start} + HdrS) == {1'b0, fad_q};
  assign need     = SW'(req_q) + HdrS;
  assign rem      = best_e_q.bytes - need;
  assign lim      = ({1'b0, cap_q} < LimP) ? {1'b0, cap_q} : LimP;
  assign brk_need = {1'b0, brk_q} + {1'b0, need};
  assign brk_hdr  = {1'b0, brk_q} + {1'b0, HdrS};
  assign up_idx   = best_q + 1'b1;
  assign lo_idx   = best_q - 1'b1;
  assign src0     = up_idx + CntW'(up_q);
  assign cnt_end  = count_q + CntW'(k_q);   // table end before the merge

  // table address and write mux
  always_comb begin
    raddr = i_q[IdxW-1:0];
    we    = 1'b0;
    waddr = pos_q[IdxW-1:0];
    wdata = best_e_q;
    case (state_q)
      ShUpRd: raddr = IdxW'(j_q - 1'b1);
      ShUpWr: begin
        we    = 1'b1;
        waddr = j_q[IdxW-1:0];
        wdata = rdata;
      end
      WrHi: begin
        we    = 1'b1;
        waddr = IdxW'(pos_q + 1'b1);
        wdata = shift_q;
      end
      NbUpRd: raddr = up_idx[IdxW-1:0];
      NbLoRd: raddr = lo_idx[IdxW-1:0];
      ShDnRd: raddr = j_q[IdxW-1:0];
      ShDnWr: begin
        we    = 1'b1;
        waddr = IdxW'(j_q - CntW'(k_q));
        wdata = rdata;
      end
      FinWr: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; fit_q <= 1'b0; cap_q <= CapRst;
      count_q <= '0; brk_q <= '0; ftot_q <= '0;
      i_q <= '0; best_q <= '0; pos_q <= '0; j_q <= '0; found_q <= 1'b0;
      up_q <= 1'b0; k_q <= '0;
      status_q <= '0; res_q <= '0;
      op_q <= 1'b0; req_q <= '0; fad_q <= '0;
      best_e_q <= '0; shift_q <= '0;
      ovalid_q <= 1'b0; ost_q <= '0; oaddr_q <= '0; oused_q <= '0; ofree_q <= '0;
    end else begin
      if (cfg_we) begin
        if (paddr[2] == 1'(fla_pkg::CfgFitMode)) fit_q <= pwdata[0];
        else cap_q <= pwdata[SW-1:0];
      end
      // output word register
      ovalid_q <= load_out || (ovalid_q && !rsp.ready);
      if (load_out) begin
        ost_q <= status_q; oaddr_q <= res_q; oused_q <= brk_q; ofree_q <= ftot_q;
      end
      case (state_q)
        Idle: begin
          if (req.valid) begin
            op_q <= req.op; req_q <= req.request_bytes;
            fad_q <= req.payload_address;
            i_q <= '0; found_q <= 1'b0; res_q <= '0; status_q <= fla_pkg::StOk;
            if (req.op == fla_pkg::OpFree && req.payload_address == '0) state_q <= Resp;
            else state_q <= ScanRd;
          end
        end
        ScanRd: begin
          if (i_q >= count_q) state_q <= Decide;
          else state_q <= ScanChk;
        end
        ScanChk: begin
          i_q <= i_q + 1'b1;
          if (op_q == fla_pkg::OpAlloc) begin
            if (elig && ge && (!fit_q || eq)) begin
              best_q <= i_q; best_e_q <= rdata; found_q <= 1'b1;
              state_q <= Decide;
            end else begin
              // best fit: keep the smallest larger block, earliest on a tie
              if (elig && ge && (!found_q || best_e_q.bytes > rdata.bytes)) begin
                best_q <= i_q; best_e_q <= rdata; found_q <= 1'b1;
              end
              state_q <= ScanRd;
            end
          end else if (addr_hit) begin
            best_q <= i_q; best_e_q <= rdata; found_q <= 1'b1;
            state_q <= Decide;
          end else begin
            state_q <= ScanRd;
          end
        end
        Decide: begin
          if (op_q == fla_pkg::OpAlloc) begin
            if (found_q) begin
              if (rem > HdrS && count_q >= SlotsC) begin
                status_q <= fla_pkg::StFull;
                state_q  <= Resp;
              end else if (rem > HdrS) begin
                // split: open a slot above the block for the free tail
                pos_q    <= best_q;
                j_q      <= count_q;
                count_q  <= count_q + 1'b1;
                shift_q  <= '{start: best_e_q.start + need[AW-1:0], bytes: rem,
                              is_free: 1'b1};
                best_e_q <= '{start: best_e_q.start, bytes: need, is_free: 1'b0};
                ftot_q   <= ftot_q - need;
                res_q    <= best_e_q.start + HdrA;
                state_q  <= (count_q == up_idx) ? WrHi : ShUpRd;
              end else begin
                pos_q    <= best_q;
                best_e_q <= '{start: best_e_q.start, bytes: best_e_q.bytes,
                              is_free: 1'b0};
                ftot_q   <= ftot_q - best_e_q.bytes;
                res_q    <= best_e_q.start + HdrA;
                state_q  <= FinWr;
              end
            end else if (brk_need > lim || brk_hdr > AddrTop) begin
              status_q <= fla_pkg::StNoMem;
              state_q  <= Resp;
            end else if (count_q >= SlotsC) begin
              status_q <= fla_pkg::StFull;
              state_q  <= Resp;
            end else begin
              // append at the break
              pos_q    <= count_q;
              count_q  <= count_q + 1'b1;
              best_e_q <= '{start: brk_q[AW-1:0], bytes: need, is_free: 1'b0};
              res_q    <= brk_q[AW-1:0] + HdrA;
              brk_q    <= brk_need[SW-1:0];
              state_q  <= FinWr;
            end
          end else if (!found_q || best_e_q.is_free) begin
            status_q <= fla_pkg::StBadFree;
            state_q  <= Resp;
          end else begin
            // free: mark it, then look at both neighbors
            ftot_q   <= ftot_q + best_e_q.bytes;
            best_e_q <= '{start: best_e_q.start, bytes: best_e_q.bytes, is_free: 1'b1};
            pos_q    <= best_q;
            up_q     <= 1'b0;
            k_q      <= '0;
            if (up_idx < count_q) state_q <= NbUpRd;
            else if (best_q != '0) state_q <= NbLoRd;
            else state_q <= MrgSet;
          end
        end
        ShUpRd: state_q <= ShUpWr;
        ShUpWr: begin
          j_q     <= j_q - 1'b1;
          state_q <= (j_q - 1'b1 == up_idx) ? WrHi : ShUpRd;
        end
        WrHi: state_q <= FinWr;
        NbUpRd: state_q <= NbUpChk;
        NbUpChk: begin
          if (rdata.is_free) begin
            best_e_q <= '{start: best_e_q.start, bytes: best_e_q.bytes + rdata.bytes,
                          is_free: 1'b1};
            up_q     <= 1'b1;
            k_q      <= k_q + 1'b1;
          end
          state_q <= (best_q != '0) ? NbLoRd : MrgSet;
        end
        NbLoRd: state_q <= NbLoChk;
        NbLoChk: begin
          if (rdata.is_free) begin
            best_e_q <= '{start: rdata.start, bytes: best_e_q.bytes + rdata.bytes,
                          is_free: 1'b1};
            pos_q    <= lo_idx;
            k_q      <= k_q + 1'b1;
          end
          state_q <= MrgSet;
        end
        // close the gaps left by merged neighbors
        MrgSet: begin
          j_q     <= src0;
          count_q <= count_q - CntW'(k_q);
          if (k_q != '0 && src0 < count_q) state_q <= ShDnRd;
          else state_q <= FinWr;
        end
        ShDnRd: state_q <= ShDnWr;
        ShDnWr: begin
          j_q     <= j_q + 1'b1;
          state_q <= (j_q + 1'b1 < cnt_end) ? ShDnRd : FinWr;
        end
        FinWr: state_q <= Resp;
        Resp: begin
          if (load_out) state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

endmodule
